// ===== rtl/core/mavg_pkg.sv =====
// Shared types and constants for the three-axis moving-average filter.
// Used by mavg_div, moving_average_three_axis and the testbench; depends on nothing.
package mavg_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 9;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_BITS   = 2;

  localparam logic [CFG_BITS-1:0]  RESET_WINDOW = CFG_BITS'(200);
  localparam logic [AXIS_BITS-1:0] AXIS_ROLL    = AXIS_BITS'(0);
  localparam logic [AXIS_BITS-1:0] AXIS_PITCH   = AXIS_BITS'(1);
  localparam logic [AXIS_BITS-1:0] AXIS_YAW     = AXIS_BITS'(2);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] roll_angle;
    logic signed [SAMPLE_BITS-1:0] pitch_angle;
    logic signed [SAMPLE_BITS-1:0] yaw_angle;
  } angle_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] roll_average;
    logic signed [SAMPLE_BITS-1:0] pitch_average;
    logic signed [SAMPLE_BITS-1:0] yaw_average;
  } average_t;

endpackage

// ===== rtl/core/mavg_div.sv =====
// Bit-serial restoring divider: signed running sum by unsigned sample count.
// One quotient bit per cycle, quotient truncates toward zero. Uses mavg_pkg.
module mavg_div
  import mavg_pkg::*;
#(
  parameter int SUM_BITS = 24,
  parameter int CNT_BITS = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_BITS-1:0]    dividend_i,
  input  logic        [CNT_BITS-1:0]    divisor_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] quotient_o
);

  localparam int ITER_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

  logic                 busy_q;
  logic                 done_q;
  logic                 neg_q;
  logic [ITER_BITS-1:0] iter_q;
  logic [CNT_BITS-1:0]  rem_q;
  logic [CNT_BITS-1:0]  dsr_q;
  logic [SUM_BITS-1:0]  quo_q;

  logic [CNT_BITS:0]    trial;
  logic                 fits;
  logic [CNT_BITS:0]    trial_sub;
  logic [SUM_BITS-1:0]  quo_signed;

  assign trial      = {rem_q, quo_q[SUM_BITS-1]};
  assign fits       = trial >= {1'b0, dsr_q};
  assign trial_sub  = trial - {1'b0, dsr_q};
  assign quo_signed = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;
  assign quotient_o = quo_signed[SAMPLE_BITS-1:0];
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_BITS'(SUM_BITS - 1);
      end else if (busy_q) begin
        iter_q <= iter_q - ITER_BITS'(1);
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_BITS-1];
      quo_q <= dividend_i[SUM_BITS-1] ? (~dividend_i + SUM_BITS'(1)) : dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
      quo_q <= {quo_q[SUM_BITS-2:0], fits};
    end
  end

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/core/moving_average_three_axis.sv =====
// Three-axis moving-average filter top level: sample ring memory, running sums,
// sequencer and a shared serial divider. Uses mavg_pkg and mavg_div.
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_word_i): one roll/pitch/yaw word.
//   out channel (out_valid_o/out_ready_i/out_word_o): one averaged word for
//   every input word, in order.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): window length; a write
//   empties all three windows. 0 acts as 1, values above MAX_WINDOW act as
//   MAX_WINDOW. Write only while the block is idle.
// Timing: one input word at a time. After accept, the update state refreshes
//   the sums and the ring memory, then the shared divider runs once per axis at
//   one quotient bit per cycle, SUM_BITS quotient bits per axis (24 with the
//   default parameters). The next word is taken only after the last result has
//   moved into the output register, so a new word is never accepted before the
//   last one is through the divider.
// Reset: windows empty, window length 200. The ring memory is not cleared;
//   only entries written since the last clear are ever read.
// Stall: the finished word sits in the output register; the next input word is
//   taken meanwhile, and its result waits until the output register frees.
module moving_average_three_axis
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  angle_t              in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output average_t            out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int SLOT_BITS = $clog2(MAX_WINDOW);
  localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + SLOT_BITS;
  localparam int CMP_BITS  = (CFG_BITS > CNT_BITS) ? CFG_BITS : CNT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

  function automatic logic [CNT_BITS-1:0] eff_win(input logic [CFG_BITS-1:0] v);
    logic [CMP_BITS-1:0] ve;
    ve = CMP_BITS'(v);
    if (ve == '0) return CNT_BITS'(1);
    if (ve > CMP_BITS'(MAX_WINDOW)) return CNT_BITS'(MAX_WINDOW);
    return CNT_BITS'(ve);
  endfunction

  state_e                        state_q;
  logic [CNT_BITS-1:0]           win_q;
  logic [CNT_BITS-1:0]           held_q;
  logic [CNT_BITS-1:0]           count_q;
  logic                          full_q;
  logic [SLOT_BITS-1:0]          slot_q;
  logic signed [SUM_BITS-1:0]    sum_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] res_q [NUM_AXES];
  logic [AXIS_BITS-1:0]          axis_q;
  logic                          start_q;
  angle_t                        samp_q;
  angle_t                        rd_q;
  logic                          out_valid_q;
  average_t                      out_q;

  angle_t                        mem [MAX_WINDOW];

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          full_d;
  logic [CNT_BITS-1:0]           slot_inc;
  logic [SLOT_BITS-1:0]          slot_d;
  logic signed [SAMPLE_BITS-1:0] new_ax [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] old_ax [NUM_AXES];
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quo;

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign full_d   = held_q >= win_q;
  assign slot_inc = CNT_BITS'(slot_q) + CNT_BITS'(1);
  assign slot_d   = (slot_inc == win_q) ? '0 : slot_inc[SLOT_BITS-1:0];

  assign new_ax[AXIS_ROLL]  = samp_q.roll_angle;
  assign new_ax[AXIS_PITCH] = samp_q.pitch_angle;
  assign new_ax[AXIS_YAW]   = samp_q.yaw_angle;
  assign old_ax[AXIS_ROLL]  = rd_q.roll_angle;
  assign old_ax[AXIS_PITCH] = rd_q.pitch_angle;
  assign old_ax[AXIS_YAW]   = rd_q.yaw_angle;

  mavg_div #(
    .SUM_BITS (SUM_BITS),
    .CNT_BITS (CNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (sum_q[axis_q]),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Ring memory: read the current slot every cycle, write it on update.
  always_ff @(posedge clk_i) begin
    rd_q <= mem[slot_q];
    if (state_q == ST_UPDATE) begin
      mem[slot_q] <= samp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= eff_win(RESET_WINDOW);
      held_q      <= '0;
      slot_q      <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        sum_q[a] <= '0;
      end
      axis_q      <= AXIS_ROLL;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      full_q      <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_fire) begin
            win_q  <= eff_win(cfg_data_i);
            held_q <= '0;
            slot_q <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
              sum_q[a] <= '0;
            end
          end else if (in_fire) begin
            full_q  <= full_d;
            count_q <= full_d ? win_q : held_q + CNT_BITS'(1);
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // drop the oldest sample once the window is full
          for (int a = 0; a < NUM_AXES; a++) begin
            sum_q[a] <= sum_q[a]
                        - (full_q ? SUM_BITS'(old_ax[a]) : SUM_BITS'(0))
                        + SUM_BITS'(new_ax[a]);
          end
          held_q  <= count_q;
          slot_q  <= slot_d;
          axis_q  <= AXIS_ROLL;
          start_q <= 1'b1;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res_q[axis_q] <= div_quo;
            if (axis_q == AXIS_YAW) begin
              state_q <= ST_DONE;
            end else begin
              axis_q  <= axis_q + AXIS_BITS'(1);
              start_q <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.roll_average  <= res_q[AXIS_ROLL];
            out_q.pitch_average <= res_q[AXIS_PITCH];
            out_q.yaw_average   <= res_q[AXIS_YAW];
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire && !cfg_fire) begin
      samp_q <= in_word_i;
    end
  end

  a_held_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= win_q)
    else $error("held count exceeds window");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_BITS'(slot_q) < win_q)
    else $error("write slot outside window");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=>
      (state_q == ST_DONE && $stable(out_q)))
    else $error("finished word overwrote a stalled output");

  a_start_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> state_q == ST_DIV)
    else $error("divider started outside the divide phase");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for moving_average_three_axis: drives angle words and
// window-length writes, predicts every averaged word, checks each one in order.
// Depends on mavg_pkg and the RTL of moving_average_three_axis only.
module testbench;
  import mavg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW  = 256;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  angle_t              in_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  average_t            out_word_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_BITS-1:0] cfg_data_i;

  moving_average_three_axis #(
    .MAX_WINDOW(MAX_WINDOW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter state mirrored for prediction.
  logic [CFG_BITS-1:0]           window_len = RESET_WINDOW;
  logic signed [SAMPLE_BITS-1:0] sample_ring [NUM_AXES][MAX_WINDOW];
  longint                        axis_sum [NUM_AXES] = '{default: 0};
  int                            held_count = 0;
  int                            write_slot = 0;

  average_t expected_averages [$];
  average_t oldest_average;
  int       errors      = 0;
  int       idle_cycles = 0;
  bit       accepted;
  bit       send_gaps   = 1'b1;
  bit       rx_stalls   = 1'b1;
  int       long_hold   = 0;

  function automatic average_t predict_average(input angle_t a);
    int                            w;
    int                            slot;
    int                            count;
    bit                            full;
    logic signed [SAMPLE_BITS-1:0] s [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] m [NUM_AXES];
    w = (window_len == 0) ? 1 : ((window_len > MAX_WINDOW) ? MAX_WINDOW : int'(window_len));
    slot  = write_slot % w;
    full  = held_count >= w;
    count = full ? w : held_count + 1;
    s[0] = a.roll_angle;
    s[1] = a.pitch_angle;
    s[2] = a.yaw_angle;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (full) begin
        axis_sum[i] -= longint'(sample_ring[i][slot]);
      end
      sample_ring[i][slot] = s[i];
      axis_sum[i] += longint'(s[i]);
      m[i] = SAMPLE_BITS'(axis_sum[i] / longint'(count));
    end
    held_count = count;
    write_slot = (slot + 1) % w;
    return average_t'{m[0], m[1], m[2]};
  endfunction

  function automatic angle_t random_angles();
    logic signed [SAMPLE_BITS-1:0] v [NUM_AXES];
    for (int i = 0; i < NUM_AXES; i++) begin
      case ($urandom_range(7))
        0: v[i] = 16'sh7FFF;
        1: v[i] = 16'sh8000;
        default: v[i] = SAMPLE_BITS'($urandom);
      endcase
    end
    return angle_t'{v[0], v[1], v[2]};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      accepted = 1'b0;
      if (out_valid_o && out_ready_i) begin
        accepted = 1'b1;
        if (expected_averages.size() == 0) begin
          $error("output word with nothing expected: %h", out_word_o);
          errors++;
        end else begin
          oldest_average = expected_averages[0];
          expected_averages.delete(0);
          if (out_word_o.roll_average !== oldest_average.roll_average) begin
            $error("roll_average: expected %0d, actual %0d",
                   oldest_average.roll_average, out_word_o.roll_average);
            errors++;
          end
          if (out_word_o.pitch_average !== oldest_average.pitch_average) begin
            $error("pitch_average: expected %0d, actual %0d",
                   oldest_average.pitch_average, out_word_o.pitch_average);
            errors++;
          end
          if (out_word_o.yaw_average !== oldest_average.yaw_average) begin
            $error("yaw_average: expected %0d, actual %0d",
                   oldest_average.yaw_average, out_word_o.yaw_average);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        accepted   = 1'b1;
        window_len = cfg_data_i;
        axis_sum   = '{default: 0};
        held_count = 0;
        write_slot = 0;
      end
      if (in_valid_i && in_ready_o) begin
        accepted = 1'b1;
        expected_averages = {expected_averages, predict_average(in_word_i)};
      end
      idle_cycles = accepted ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (long_hold) @(negedge clk_i);
        long_hold = 0;
      end
      stall = rx_stalls ? $urandom_range(19) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Enter and leave at a falling edge; valid stays high for the next call.
  task automatic send_angles(input angle_t word);
    int gap;
    gap = send_gaps ? $urandom_range(19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_averages.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_BITS-1:0] len);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_window();
    send_angles(angle_t'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    send_angles(angle_t'{16'sh8000, 16'sh8000, 16'sh8000});
    send_angles(angle_t'{16'sh0000, 16'sh0000, 16'sh0000});
    send_angles(angle_t'{16'sh7FFF, 16'sh8000, -16'sd1});
    send_angles(angle_t'{-16'sd1, 16'sd1, 16'sh0000});
    send_angles(angle_t'{16'sh8000, 16'sh8000, 16'sh7FFF});
  endtask

  task automatic test_short_windows();
    write_window(CFG_BITS'(1));
    send_angles(angle_t'{16'sh7FFF, 16'sh8000, 16'sd1});
    send_angles(angle_t'{16'sh8000, 16'sh7FFF, -16'sd1});
    send_angles(angle_t'{16'sh1234, -16'sd1, 16'sh0000});
    write_window(CFG_BITS'(0));
    send_angles(angle_t'{16'shAAAA, 16'sh5555, 16'sh0000});
    send_angles(angle_t'{16'sh5555, 16'shAAAA, -16'sd1});
    write_window(CFG_BITS'(3));
    send_angles(angle_t'{-16'sd1, -16'sd1, 16'sd1});
    send_angles(angle_t'{-16'sd1, 16'sd0, 16'sd1});
    send_angles(angle_t'{16'sd0, -16'sd2, 16'sd2});
    send_angles(angle_t'{16'sh7FFF, 16'sh8000, -16'sd3});
    send_angles(angle_t'{16'sh7FFF, 16'sh8000, 16'sd0});
    send_angles(angle_t'{16'sh7FFF, 16'sh8000, 16'sd5});
    send_angles(angle_t'{-16'sd5, 16'sd5, 16'sd1});
  endtask

  task automatic test_backpressure();
    write_window(CFG_BITS'(4));
    send_gaps = 1'b0;
    long_hold = LONG_HOLD;
    repeat (12) send_angles(random_angles());
    wait_idle();
    send_gaps = 1'b1;
  endtask

  task automatic test_random_windows();
    logic [CFG_BITS-1:0] len;
    int                  count;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: len = CFG_BITS'(2);
        1: len = CFG_BITS'(MAX_WINDOW);
        2: len = CFG_BITS'(7);
        3: len = '1;
        4: len = CFG_BITS'(1);
        5: len = '0;
        6: len = CFG_BITS'(33);
        7: len = CFG_BITS'(257);
        8: len = CFG_BITS'(128);
        default: len = CFG_BITS'($urandom_range(1, 80));
      endcase
      write_window(len);
      send_gaps = (phase % 3) != 2;
      rx_stalls = (phase % 3) != 2;
      count = (len >= MAX_WINDOW) ? 280 : 60;
      repeat (count) send_angles(random_angles());
    end
    send_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_window();
    test_short_windows();
    test_backpressure();
    test_random_windows();
    wait_idle();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mavg_pkg.sv
rtl/core/mavg_div.sv
rtl/core/moving_average_three_axis.sv
dv/testbench.sv
